/* hw/rtl/f64nhz_pkg.sv */
// ----------------------------------------------------------------------------
// f64nhz_pkg
// Shared types and constants for the binary64 hertz to nanohertz converter.
// ----------------------------------------------------------------------------
package f64nhz_pkg;

    localparam int IN_W    = 64;
    localparam int OUT_W   = 64;
    localparam int FRAC_W  = 52;
    localparam int SIG_W   = 53;
    localparam int PROD_W  = 83;
    localparam int SHIFT_W = 11;

    localparam logic [29:0]       NHZ_PER_HZ = 30'd1000000000;
    localparam logic [10:0]       EXP_BIAS_SHIFT = 11'd1075;
    localparam logic [IN_W-1:0]   LIMIT_BITS =
        (64'(1057) << 52) | (64'(1266874890) << 18);

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_INVALID   = 2'd1,
        ST_TOO_LARGE = 2'd2,
        ST_ZERO      = 2'd3
    } status_t;

endpackage

/* hw/rtl/f64nhz_if.sv */
// ----------------------------------------------------------------------------
// f64nhz_if
// Valid/ready channel carrying an input or a result item.
// ----------------------------------------------------------------------------
interface f64nhz_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] hertz_bits;
    modport source (output valid, output hertz_bits, input ready);
    modport sink   (input valid, input hertz_bits, output ready);
endinterface

interface f64nhz_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] nanohertz;
    logic [1:0]  status;
    modport source (output valid, output nanohertz, output status, input ready);
    modport sink   (input valid, input nanohertz, input status, output ready);
endinterface

/* hw/rtl/float64_hz_to_nanohertz_unit.sv */
// ----------------------------------------------------------------------------
// float64_hz_to_nanohertz_unit
// Converts a binary64 frequency in hertz to a rounded 64-bit nanohertz count.
// ----------------------------------------------------------------------------
//  channel   direction  payload
//  in_ch     sink       hertz_bits[63:0]
//  out_ch    source     nanohertz[63:0], status[1:0]
//
// Four register stages: decode, partial products, sum and shift, round.
// One item per cycle sustained while the output is not stalled. All stages advance
// together when the output register is empty or being taken, so a stall
// holds every stage. Reset clears only the valid bits.
module float64_hz_to_nanohertz_unit (
    input  logic clk,
    input  logic rst_n,
    f64nhz_in_if.sink    in_ch,
    f64nhz_out_if.source out_ch
);
    import f64nhz_pkg::*;

    logic adv;
    logic v1_reg, v2_reg, v3_reg, v4_reg;

    // Stage 1: decode
    logic            done1_reg;
    status_t         st1_reg;
    logic [SIG_W-1:0] sig1_reg;
    logic [SHIFT_W-1:0] sh1_reg;
    // Stage 2: partial products
    logic            done2_reg;
    status_t         st2_reg;
    logic [61:0]     lo2_reg;
    logic [50:0]     hi2_reg;
    logic [SHIFT_W-1:0] sh2_reg;
    // Stage 3: shifted value and round bit
    logic            done3_reg;
    status_t         st3_reg;
    logic [OUT_W-1:0] val3_reg;
    logic            rnd3_reg;
    // Stage 4: output
    status_t         st4_reg;
    logic [OUT_W-1:0] val4_reg;

    assign adv = !out_ch.valid || out_ch.ready;
    assign in_ch.ready = adv;

    // Decode
    logic [10:0] bexp;
    logic [FRAC_W-1:0] frac;
    logic done1_next;
    status_t st1_next;
    always_comb
    begin
        bexp = in_ch.hertz_bits[62:52];
        frac = in_ch.hertz_bits[FRAC_W-1:0];
        done1_next = 1'b1;
        st1_next = ST_OK;
        if (bexp == 11'h7ff)
            st1_next = ST_INVALID;
        else if (bexp == 11'd0 && frac == '0)
            st1_next = ST_INVALID;
        else if (in_ch.hertz_bits[63])
            st1_next = ST_INVALID;
        else if (in_ch.hertz_bits >= LIMIT_BITS)
            st1_next = ST_TOO_LARGE;
        else if (bexp == 11'd0)
            st1_next = ST_ZERO;
        else
            done1_next = 1'b0;
    end

    // Sum and shift
    logic [PROD_W-1:0] prod;
    logic [PROD_W:0]   shifted;
    logic [PROD_W-1:0] rbits;
    logic done3_next, rnd3_next;
    always_comb
    begin
        prod = {21'd0, lo2_reg} + ({32'd0, hi2_reg} << 32);
        shifted = '0;
        rbits = '0;
        rnd3_next = 1'b0;
        done3_next = done2_reg;
        if (!done2_reg)
        begin
            if (sh2_reg >= 11'd128)
                done3_next = 1'b1;
            else
            begin
                shifted = {1'b0, prod >> sh2_reg[6:0]};
                rbits = prod >> (sh2_reg[6:0] - 7'd1);
                rnd3_next = rbits[0];
            end
        end
    end

    logic st3_big;
    assign st3_big = (shifted[PROD_W:OUT_W] != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_ch.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            done1_reg <= done1_next;
            st1_reg   <= st1_next;
            sig1_reg  <= {1'b1, frac};
            sh1_reg   <= EXP_BIAS_SHIFT - bexp;

            done2_reg <= done1_reg;
            st2_reg   <= st1_reg;
            lo2_reg   <= 62'(sig1_reg[31:0]) * 62'(NHZ_PER_HZ);
            hi2_reg   <= 51'(sig1_reg[SIG_W-1:32]) * 51'(NHZ_PER_HZ);
            sh2_reg   <= sh1_reg;

            done3_reg <= done3_next || (!done2_reg && st3_big);
            st3_reg   <= done2_reg ? st2_reg :
                         (done3_next ? ST_ZERO : ST_TOO_LARGE);
            val3_reg  <= shifted[OUT_W-1:0];
            rnd3_reg  <= rnd3_next;

            if (done3_reg)
            begin
                st4_reg  <= st3_reg;
                val4_reg <= '0;
            end
            else if (rnd3_reg && val3_reg == '1)
            begin
                st4_reg  <= ST_TOO_LARGE;
                val4_reg <= '0;
            end
            else if (val3_reg + OUT_W'(rnd3_reg) == '0)
            begin
                st4_reg  <= ST_ZERO;
                val4_reg <= '0;
            end
            else
            begin
                st4_reg  <= ST_OK;
                val4_reg <= val3_reg + OUT_W'(rnd3_reg);
            end
        end
    end

    assign out_ch.valid     = v4_reg;
    assign out_ch.nanohertz = val4_reg;
    assign out_ch.status    = st4_reg;

endmodule

/* tb/f64nhz_checker.sv */
// ----------------------------------------------------------------------------
// f64nhz_checker
// Watches both channels of the converter, computes the expected nanohertz
// count and status for every accepted item and compares in order.
// ----------------------------------------------------------------------------
module f64nhz_checker
    import f64nhz_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    f64nhz_in_if.sink    in_mon,
    f64nhz_out_if.sink   out_mon,
    output int           error_count,
    output int           pending_count
);

    typedef struct packed {
        logic [63:0] nanohertz;
        status_t     status;
    } conversion_t;

    conversion_t conversions_due[$];

    function automatic conversion_t convert_hertz(logic [63:0] bits);
        conversion_t res;
        logic [10:0]  bexp;
        logic [51:0]  frac;
        logic [127:0] prod;
        logic [127:0] scaled;
        logic [63:0]  value;
        int           shift;
        logic         half_bit;
        bexp = bits[62:52];
        frac = bits[51:0];
        res.nanohertz = '0;
        if (bexp == 11'h7ff || (bexp == 0 && frac == 0) || bits[63]) begin
            res.status = ST_INVALID;
            return res;
        end
        if (bits >= LIMIT_BITS) begin
            res.status = ST_TOO_LARGE;
            return res;
        end
        if (bexp == 0) begin
            res.status = ST_ZERO;
            return res;
        end
        prod = 128'({1'b1, frac}) * 128'(1000000000);
        shift = 1075 - int'(bexp);
        if (shift >= 128) begin
            res.status = ST_ZERO;
            return res;
        end
        scaled = prod >> shift;
        if (scaled[127:64] != 0) begin
            res.status = ST_TOO_LARGE;
            return res;
        end
        value = scaled[63:0];
        half_bit = prod[shift-1];
        if (half_bit) begin
            if (value == '1) begin
                res.status = ST_TOO_LARGE;
                return res;
            end
            value = value + 64'd1;
        end
        if (value == 0) begin
            res.status = ST_ZERO;
            return res;
        end
        res.nanohertz = value;
        res.status = ST_OK;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        conversion_t want;
        if (!rst_n)
        begin
            error_count <= 0;
            pending_count <= 0;
        end
        else
        begin
            if (in_mon.valid && in_mon.ready)
                conversions_due.insert(conversions_due.size(),
                                       convert_hertz(in_mon.hertz_bits));
            if (out_mon.valid && out_mon.ready)
            begin
                if (conversions_due.size() == 0)
                begin
                    if (error_count < 10)
                        $display("Unexpected result nanohertz=%h status=%0d",
                                 out_mon.nanohertz, out_mon.status);
                    error_count <= error_count + 1;
                end
                else
                begin
                    want = conversions_due.pop_front();
                    if (want.nanohertz !== out_mon.nanohertz ||
                        want.status !== out_mon.status)
                    begin
                        if (error_count < 10)
                            $display("Mismatch: expected %h/%0d, got %h/%0d",
                                     want.nanohertz, want.status,
                                     out_mon.nanohertz, out_mon.status);
                        error_count <= error_count + 1;
                    end
                end
            end
            pending_count <= conversions_due.size();
        end
    end

endmodule

/* tb/float64_hz_to_nanohertz_unit_test.sv */
// ----------------------------------------------------------------------------
// float64_hz_to_nanohertz_unit_test
// Drives directed and random binary64 frequencies through the converter
// under several idling patterns and reports the verdict from the checker.
// ----------------------------------------------------------------------------
module float64_hz_to_nanohertz_unit_test;
    import f64nhz_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   error_count;
    int   pending_count;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   quiet_cycles = 0;

    f64nhz_in_if  in_ch ();
    f64nhz_out_if out_ch ();

    float64_hz_to_nanohertz_unit DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (in_ch.sink),
        .out_ch(out_ch.source)
    );

    f64nhz_checker checker_inst (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_mon       (in_ch.sink),
        .out_mon      (out_ch.sink),
        .error_count  (error_count),
        .pending_count(pending_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        else
            out_ch.ready <= 1'b0;
    end

    // Watchdog over cycles in which neither channel moves an item.
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else if (rst_n)
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic logic [63:0] make_double(logic [10:0] bexp);
        return {1'b0, bexp, 20'($urandom), 32'($urandom)};
    endfunction

    function automatic logic [63:0] random_hertz();
        int pick;
        pick = $urandom_range(99);
        if (pick < 55)          // inside the useful range, many ok results
            return make_double(11'($urandom_range(1057, 1000)));
        else if (pick < 70)     // small values around half a nanohertz
            return make_double(11'($urandom_range(1000, 940)));
        else if (pick < 78)     // near the upper limit
            return LIMIT_BITS + 64'($signed($urandom_range(2000)) - 1000);
        else if (pick < 86)     // ties and exact values
            return {1'b0, 11'($urandom_range(1057, 1020)), 52'($urandom) << 30};
        else
            return {$urandom, $urandom};
    endfunction

    task automatic send_hertz(logic [63:0] bits);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.hertz_bits <= bits;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
    endtask

    logic [63:0] directed_values[] = '{
        64'h0000000000000000, 64'h8000000000000000, 64'h7ff0000000000000,
        64'hfff0000000000000, 64'h7ff8000000000001, 64'hbff0000000000000,
        64'h0000000000000001, 64'h000fffffffffffff, 64'h0010000000000000,
        64'h3ff0000000000000, 64'h3e112e0be826d695, 64'h3e012e0be826d695,
        64'h3e012e0be826d694, 64'h3e012e0be826d696, 64'h3d00000000000000,
        64'h7fefffffffffffff, 64'h4212a05f20000000, 64'h4212a05f1fffffff,
        64'h4212a05f1ffffffe, 64'h41cdcd6500000000, 64'h3fe0000000000000,
        64'h4024000000000000, 64'h7fffffffffffffff, 64'hffffffffffffffff
    };

    initial
    begin
        int phase;
        in_ch.valid <= 1'b0;
        in_ch.hertz_bits <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed_values[i])
            send_hertz(directed_values[i]);
        for (phase = 0; phase < 4; phase++)
        begin
            send_idle_pct = (phase == 1) ? 65 : (phase == 3) ? 34 : 0;
            recv_stall_pct = (phase == 2) ? 65 : (phase == 3) ? 34 : 0;
            repeat (215)
                send_hertz(random_hertz());
        end
        in_ch.valid <= 1'b0;
        recv_stall_pct = 0;
        while (pending_count != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/f64nhz_pkg.sv
hw/rtl/f64nhz_if.sv
hw/rtl/float64_hz_to_nanohertz_unit.sv
tb/f64nhz_checker.sv
tb/float64_hz_to_nanohertz_unit_test.sv
